>>> hw/rtl/bra_pkg.sv
// Shared types and constants for the bitmap run allocator.
// No dependencies; imported by bitmap_run_allocator, bra_checker and tb_top.
`timescale 1ns / 1ps

package bra_pkg;

  // The map is stored and scanned one byte-wide digit at a time.
  localparam int DigitBits  = 8;
  localparam int DigitShift = 3;

  // Width of the configuration write data (widest register).
  localparam int CfgWidth = 11;

  typedef logic [DigitBits-1:0] digit_t;

  // Operation codes carried on op_i.
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_WRITE = 2'd1,
    OP_TEST  = 2'd2,
    OP_FILL  = 2'd3
  } op_e;

  // Configuration register indexes.
  localparam logic CFG_USED_BITS  = 1'b0;
  localparam logic CFG_FILL_VALUE = 1'b1;

endpackage

>>> hw/rtl/bitmap_run_allocator.sv
// First-fit run allocator over a one-bit-per-unit map held in a byte-wide memory.
// Depends on bra_pkg for digit width, operation codes and register indexes.
`timescale 1ns / 1ps

// A request is taken when start_i is high and busy_o is low; its single result
// is shown for one cycle with done_o and must be taken then, since the block
// cannot hold it. The map sits in a memory of MAP_BITS/8 bytes (MAP_BITS must
// be a multiple of 8) with one read and one write port. Clear, fill and alloc
// walk it one byte per cycle; write reads and writes back one byte at a time.
// After reset the block is busy while it clears the map. Test reads the byte
// that holds the bit (S_TEST_RD, then S_TEST_DATA). Fill sweeps the whole map
// with the fill value. Write reads each byte touched by the run and writes it
// back (S_WR_RD, then S_WR_MOD). Alloc streams bytes in until the run is found
// or the used size is reached, then inverts the bytes of a nonzero run the same
// way as write.
module bitmap_run_allocator
  import bra_pkg::*;
#(
  parameter int MAP_BITS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Command request
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          op_i,
  input  logic [9:0]          bit_index_i,
  input  logic [10:0]         run_length_i,
  input  logic                bit_value_i,
  // Result
  output logic                done_o,
  output logic                status_o,
  output logic [9:0]          first_index_o,
  output logic                bit_state_o,
  // Configuration writes
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i
);

  localparam int NumWords = MAP_BITS / DigitBits;
  localparam int AW       = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int SW       = ($clog2(MAP_BITS + 1) > CfgWidth) ? $clog2(MAP_BITS + 1) : CfgWidth;
  localparam int EW       = SW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_WR_RD,
    S_WR_MOD,
    S_TEST_RD,
    S_TEST_DATA
  } state_e;

  state_e              state_q;
  logic [CfgWidth-1:0] used_bits_q;
  logic                fill_value_q;
  logic [AW-1:0]       addr_q;
  logic [AW-1:0]       data_addr_q;
  logic                pend_q;
  logic                clr_val_q;
  logic                clr_rsp_q;
  logic [SW-1:0]       idx_q;
  logic [EW-1:0]       wr_end_q;
  logic [CfgWidth-1:0] len_q;
  logic [SW-1:0]       need_q;
  logic [SW-1:0]       run_q;
  logic                val_q;
  logic                done_q;
  logic                status_q;
  logic [9:0]          first_q;
  logic                bit_state_q;

  digit_t              mem_q [NumWords];
  digit_t              rdata_q;
  logic                mem_we;
  digit_t              mem_wdata;

  logic [SW-1:0]       size;
  logic [SW-1:0]       req_idx;
  logic [EW-1:0]       req_end_sum;
  logic [EW-1:0]       req_end;

  logic [SW-1:0]       data_base;
  logic [SW-1:0]       addr_base;
  logic [SW-1:0]       run_v;
  logic                hit;
  logic [SW-1:0]       hit_pos;
  logic [SW-1:0]       hit_first;
  logic                scan_end;
  digit_t              wr_mask;
  logic                wr_last;

  // Effective map size: used_bits capped at the map depth.
  assign size = (SW'(used_bits_q) < SW'(MAP_BITS)) ? SW'(used_bits_q) : SW'(MAP_BITS);

  // End of a requested write run, clipped at the used size.
  assign req_idx     = SW'(bit_index_i);
  assign req_end_sum = EW'(req_idx) + EW'(run_length_i);
  assign req_end     = (req_end_sum < EW'(size)) ? req_end_sum : EW'(size);

  // Bit positions of the byte in the read register and of the byte addressed.
  assign data_base = SW'({data_addr_q, {DigitShift{1'b0}}});
  assign addr_base = SW'({addr_q, {DigitShift{1'b0}}});

  // Scan one byte: extend or break the current run bit by bit.
  always_comb begin
    run_v   = run_q;
    hit     = 1'b0;
    hit_pos = '0;
    for (int j = 0; j < DigitBits; j++) begin
      if (!hit && (data_base + SW'(j) < size)) begin
        if (rdata_q[j] == val_q) begin
          run_v = run_v + SW'(1);
          if (run_v == need_q) begin
            hit     = 1'b1;
            hit_pos = data_base + SW'(j);
          end
        end else begin
          run_v = '0;
        end
      end
    end
  end

  assign hit_first = hit_pos + SW'(1) - need_q;
  assign scan_end  = (data_base + SW'(DigitBits)) >= size;

  // Mask of the bits in the addressed byte that fall inside the write run.
  always_comb begin
    for (int j = 0; j < DigitBits; j++) begin
      wr_mask[j] = ((addr_base + SW'(j)) >= idx_q) && (EW'(addr_base + SW'(j)) < wr_end_q);
    end
  end

  assign wr_last = (EW'(addr_base) + EW'(DigitBits)) >= wr_end_q;

  // Memory write port: clearing sweep or read-modify-write of one byte.
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = {DigitBits{clr_val_q}};
    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_WR_MOD: begin
        mem_we    = 1'b1;
        mem_wdata = (rdata_q & ~wr_mask) | (wr_mask & {DigitBits{val_q}});
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Map memory: one write and one registered read, both at addr_q.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr_q] <= mem_wdata;
    end
    rdata_q <= mem_q[addr_q];
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_bits_q  <= CfgWidth'(1024);
      fill_value_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_USED_BITS:  used_bits_q  <= cfg_wdata_i;
        CFG_FILL_VALUE: fill_value_q <= cfg_wdata_i[0];
        default:        used_bits_q  <= used_bits_q;
      endcase
    end
  end

  // Sequencer and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      addr_q      <= '0;
      data_addr_q <= '0;
      pend_q      <= 1'b0;
      clr_val_q   <= 1'b0;
      clr_rsp_q   <= 1'b0;
      idx_q       <= '0;
      wr_end_q    <= '0;
      len_q       <= '0;
      need_q      <= '0;
      run_q       <= '0;
      val_q       <= 1'b0;
      done_q      <= 1'b0;
      status_q    <= 1'b0;
      first_q     <= '0;
      bit_state_q <= 1'b0;
    end else begin
      done_q      <= 1'b0;
      data_addr_q <= addr_q;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            status_q    <= 1'b0;
            first_q     <= '0;
            bit_state_q <= 1'b0;
            val_q       <= bit_value_i;
            len_q       <= run_length_i;
            idx_q       <= req_idx;
            case (op_e'(op_i))
              OP_ALLOC: begin
                need_q  <= (run_length_i == '0) ? SW'(1) : SW'(run_length_i);
                run_q   <= '0;
                addr_q  <= '0;
                pend_q  <= 1'b0;
                state_q <= S_SCAN;
              end
              OP_WRITE: begin
                wr_end_q <= req_end;
                addr_q   <= req_idx[AW+DigitShift-1:DigitShift];
                if (EW'(req_idx) >= req_end) begin
                  done_q <= 1'b1;
                end else begin
                  state_q <= S_WR_RD;
                end
              end
              OP_TEST: begin
                addr_q  <= req_idx[AW+DigitShift-1:DigitShift];
                state_q <= S_TEST_RD;
              end
              OP_FILL: begin
                addr_q    <= '0;
                clr_val_q <= fill_value_q;
                clr_rsp_q <= 1'b1;
                state_q   <= S_CLEAR;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end

        // Sweep the whole map with one value, after reset or for fill.
        S_CLEAR: begin
          addr_q <= addr_q + AW'(1);
          if (addr_q == AW'(NumWords - 1)) begin
            done_q  <= clr_rsp_q;
            state_q <= S_IDLE;
          end
        end

        // Stream bytes in; each cycle the byte read last cycle is scanned.
        S_SCAN: begin
          addr_q <= addr_q + AW'(1);
          pend_q <= 1'b1;
          if (pend_q) begin
            run_q <= run_v;
            if (hit) begin
              first_q <= hit_first[9:0];
              if (len_q != '0) begin
                idx_q    <= hit_first;
                wr_end_q <= EW'(hit_pos) + EW'(1);
                addr_q   <= hit_first[AW+DigitShift-1:DigitShift];
                val_q    <= ~val_q;
                state_q  <= S_WR_RD;
              end else begin
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end
            end else if (scan_end) begin
              status_q <= 1'b1;
              done_q   <= 1'b1;
              state_q  <= S_IDLE;
            end
          end
        end

        S_WR_RD: begin
          state_q <= S_WR_MOD;
        end

        // The byte is written back this cycle; move on or finish.
        S_WR_MOD: begin
          if (wr_last) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            addr_q  <= addr_q + AW'(1);
            state_q <= S_WR_RD;
          end
        end

        S_TEST_RD: begin
          state_q <= S_TEST_DATA;
        end

        // Bits at or beyond the used size read as zero.
        S_TEST_DATA: begin
          bit_state_q <= (idx_q < size) && rdata_q[idx_q[DigitShift-1:0]];
          done_q      <= 1'b1;
          state_q     <= S_IDLE;
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign first_index_o = first_q;
  assign bit_state_o   = bit_state_q;

endmodule

>>> sim/bra_checker.sv
// Scoreboard for the bitmap run allocator: watches requests, register writes and results.
// Depends on bra_pkg for operation codes, register indexes and the write data width.
`timescale 1ns / 1ps

module bra_checker
  import bra_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic [1:0]          op_i,
  input  logic [9:0]          bit_index_i,
  input  logic [10:0]         run_length_i,
  input  logic                bit_value_i,
  input  logic                done_i,
  input  logic                status_i,
  input  logic [9:0]          first_index_i,
  input  logic                bit_state_i,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i,
  output int                  error_count_o,
  output int                  pending_o,
  output int                  checked_o
);

  localparam int MapBits = 1024;

  typedef struct packed {
    logic       status;
    logic [9:0] first_index;
    logic       bit_state;
  } alloc_result_t;

  // Local copy of the allocator state and its registers.
  logic [MapBits-1:0] usage_map;
  logic [10:0]        used_bits;
  logic               fill_value;

  alloc_result_t expected_results[$];

  // Applies one request to the local map and returns the result it must give.
  task automatic predict_allocator_result(input logic [1:0] op, input logic [9:0] idx,
                                          input logic [10:0] len, input logic val,
                                          output alloc_result_t res);
    int size;
    int need;
    int run;
    int start;
    bit found;
    begin
      size = (used_bits > MapBits) ? MapBits : int'(used_bits);
      res = '0;
      case (op_e'(op))
        OP_ALLOC: begin
          // First fit: scan from bit 0 for a run of matching bits.
          need = (len == 0) ? 1 : int'(len);
          run = 0;
          start = 0;
          found = 1'b0;
          for (int i = 0; i < size && !found; i++) begin
            if (usage_map[i] == val) begin
              run++;
              if (run == need) begin
                start = i + 1 - need;
                found = 1'b1;
              end
            end else begin
              run = 0;
            end
          end
          if (found) begin
            res.first_index = start[9:0];
            // A zero-length request only reports the first match.
            for (int k = 0; k < int'(len) && start + k < size; k++) begin
              usage_map[start + k] = ~val;
            end
          end else begin
            res.status = 1'b1;
          end
        end
        OP_WRITE: begin
          // The run is clipped at the used size.
          for (int k = 0; k < int'(len) && int'(idx) + k < size; k++) begin
            usage_map[int'(idx) + k] = val;
          end
        end
        OP_TEST: begin
          if (int'(idx) < size) begin
            res.bit_state = usage_map[idx];
          end
        end
        default: begin
          // Fill covers the whole map, beyond the used size too.
          usage_map = {MapBits{fill_value}};
        end
      endcase
    end
  endtask

  // Results are retired before a new request is predicted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    alloc_result_t predicted;
    alloc_result_t oldest;
    if (!rst_ni) begin
      usage_map = '0;
      used_bits = 11'd1024;
      fill_value = 1'b0;
      expected_results.delete();
      error_count_o = 0;
      pending_o = 0;
      checked_o = 0;
    end else begin
      if (done_i) begin
        if (expected_results.size() == 0) begin
          error_count_o++;
          if (error_count_o <= 10) begin
            $display("[%0t] result with no request outstanding: status %0b first %0d state %0b",
                     $time, status_i, first_index_i, bit_state_i);
          end
        end else begin
          oldest = expected_results.pop_front();
          checked_o++;
          if (status_i !== oldest.status || first_index_i !== oldest.first_index ||
              bit_state_i !== oldest.bit_state) begin
            error_count_o++;
            if (error_count_o <= 10) begin
              $display("[%0t] mismatch: expected status %0b first %0d state %0b, got %0b %0d %0b",
                       $time, oldest.status, oldest.first_index, oldest.bit_state,
                       status_i, first_index_i, bit_state_i);
            end
          end
        end
      end

      if (cfg_we_i) begin
        if (cfg_index_i == CFG_USED_BITS) begin
          used_bits = cfg_wdata_i[10:0];
        end else begin
          fill_value = cfg_wdata_i[0];
        end
      end

      if (start_i && !busy_i) begin
        predict_allocator_result(op_i, bit_index_i, run_length_i, bit_value_i, predicted);
        expected_results.push_back(predicted);
      end

      pending_o = expected_results.size();
    end
  end

endmodule

>>> sim/tb_top.sv
// Top of the bitmap run allocator testbench: clock, reset, stimulus and verdict.
// Depends on bra_pkg, bitmap_run_allocator and bra_checker.
`timescale 1ns / 1ps

module tb_top
  import bra_pkg::*;
();

  localparam int CycleLimit = 2000000;
  localparam int PhaseItems = 95;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [1:0]          op_i;
  logic [9:0]          bit_index_i;
  logic [10:0]         run_length_i;
  logic                bit_value_i;
  logic                done_o;
  logic                status_o;
  logic [9:0]          first_index_o;
  logic                bit_state_o;
  logic                cfg_we_i;
  logic                cfg_index_i;
  logic [CfgWidth-1:0] cfg_wdata_i;

  int error_count;
  int pending;
  int checked;
  int cycle_count;
  int op_count[4];
  int reg_writes;
  int map_size;
  bit idle_enable;

  bitmap_run_allocator #(.MAP_BITS(1024)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .op_i          (op_i),
    .bit_index_i   (bit_index_i),
    .run_length_i  (run_length_i),
    .bit_value_i   (bit_value_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .first_index_o (first_index_o),
    .bit_state_o   (bit_state_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  bra_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .op_i          (op_i),
    .bit_index_i   (bit_index_i),
    .run_length_i  (run_length_i),
    .bit_value_i   (bit_value_i),
    .done_i        (done_o),
    .status_i      (status_o),
    .first_index_i (first_index_o),
    .bit_state_i   (bit_state_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .error_count_o (error_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  // 12 ns clock.
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Watchdog on a cycle counter.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  // Presents one request at a falling edge and holds it until the block takes it.
  task automatic issue_request(input op_e op, input logic [9:0] idx,
                               input logic [10:0] len, input logic val);
    int gap;
    begin
      if (idle_enable && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 6);
        start_i <= 1'b0;
        // Sometimes let the block go idle first so the gap lands between requests.
        if ($urandom_range(0, 2) == 0) begin
          @(negedge clk_i);
          while (busy_o) @(negedge clk_i);
        end
        repeat (gap) @(negedge clk_i);
      end
      start_i <= 1'b1;
      op_i <= op;
      bit_index_i <= idx;
      run_length_i <= len;
      bit_value_i <= val;
      op_count[op]++;
      while (busy_o) @(negedge clk_i);
      @(negedge clk_i);
    end
  endtask

  // Register writes wait until the block is idle and every result is in.
  task automatic write_register(input logic idx, input logic [CfgWidth-1:0] data);
    begin
      start_i <= 1'b0;
      @(negedge clk_i);
      while (pending != 0 || busy_o) @(negedge clk_i);
      repeat (4) @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_wdata_i <= data;
      @(negedge clk_i);
      cfg_we_i <= 1'b0;
      reg_writes++;
      if (idx == CFG_USED_BITS) begin
        map_size = (data > 1024) ? 1024 : int'(data);
      end
    end
  endtask

  // Mostly an index inside the used part of the map, sometimes anywhere.
  function automatic logic [9:0] pick_index();
    if (map_size == 0 || $urandom_range(0, 7) == 0) begin
      return 10'($urandom_range(0, 1023));
    end
    return 10'($urandom_range(0, map_size - 1));
  endfunction

  // Allocation-heavy traffic: allocate, release, probe, and now and then clear the map.
  task automatic issue_random_request();
    int pick;
    int len_pick;
    logic [10:0] len;
    logic val;
    begin
      pick = $urandom_range(0, 99);
      len_pick = $urandom_range(0, 99);
      if (len_pick < 70) begin
        len = 11'($urandom_range(1, 16));
      end else if (len_pick < 85) begin
        len = 11'($urandom_range(0, (map_size > 1) ? map_size : 1));
      end else if (len_pick < 93) begin
        len = 11'd0;
      end else begin
        len = 11'($urandom_range(0, 2047));
      end
      if (pick < 45) begin
        val = ($urandom_range(0, 4) != 0) ? 1'b0 : 1'b1;
        issue_request(OP_ALLOC, 10'($urandom_range(0, 1023)), len, val);
      end else if (pick < 68) begin
        val = ($urandom_range(0, 4) != 0) ? 1'b0 : 1'b1;
        issue_request(OP_WRITE, pick_index(), len, val);
      end else if (pick < 90) begin
        issue_request(OP_TEST, pick_index(), len, 1'($urandom_range(0, 1)));
      end else if (pick < 95) begin
        issue_request(OP_FILL, pick_index(), len, 1'($urandom_range(0, 1)));
      end else begin
        // Raw noise on every field.
        issue_request(op_e'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)),
                      11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    int used_setting[10];
    rst_ni = 1'b0;
    start_i = 1'b0;
    op_i = '0;
    bit_index_i = '0;
    run_length_i = '0;
    bit_value_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = 1'b0;
    cfg_wdata_i = '0;
    cycle_count = 0;
    reg_writes = 0;
    map_size = 1024;
    idle_enable = 1'b1;
    foreach (op_count[i]) op_count[i] = 0;
    used_setting = '{1024, 1, 2047, 0, 37, 300, 1000, 8, 513, 1024};

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part on the cleared map with the full size.
    issue_request(OP_TEST, 10'd0, 11'd0, 1'b0);
    issue_request(OP_ALLOC, 10'd0, 11'd0, 1'b1);       // no set bit anywhere
    issue_request(OP_ALLOC, 10'd0, 11'd0, 1'b0);       // zero length: first match only
    issue_request(OP_ALLOC, 10'd0, 11'd1024, 1'b0);    // whole map
    issue_request(OP_ALLOC, 10'd0, 11'd1, 1'b0);       // no room
    issue_request(OP_TEST, 10'd1023, 11'd0, 1'b0);
    issue_request(OP_WRITE, 10'd1023, 11'd2047, 1'b0); // clipped at the end
    issue_request(OP_WRITE, 10'd100, 11'd8, 1'b0);
    issue_request(OP_ALLOC, 10'd0, 11'd9, 1'b0);       // longest free run is 8
    issue_request(OP_ALLOC, 10'd0, 11'd8, 1'b0);
    issue_request(OP_ALLOC, 10'd0, 11'd1, 1'b0);       // last bit of the map
    issue_request(OP_ALLOC, 10'd0, 11'd1025, 1'b1);    // longer than the map
    issue_request(OP_WRITE, 10'd0, 11'd0, 1'b0);
    issue_request(OP_WRITE, 10'd3, 11'd5, 1'b0);
    issue_request(OP_ALLOC, 10'd0, 11'd2, 1'b0);
    issue_request(OP_FILL, 10'd0, 11'd0, 1'b1);
    issue_request(OP_TEST, 10'd512, 11'd0, 1'b0);
    write_register(CFG_FILL_VALUE, 11'd1);
    issue_request(OP_FILL, 10'd0, 11'd0, 1'b0);
    issue_request(OP_TEST, 10'd1023, 11'd0, 1'b0);
    // Empty map: nothing can be written, read or found.
    write_register(CFG_USED_BITS, 11'd0);
    issue_request(OP_WRITE, 10'd0, 11'd5, 1'b0);
    issue_request(OP_TEST, 10'd0, 11'd0, 1'b0);
    issue_request(OP_ALLOC, 10'd0, 11'd0, 1'b1);
    // A used size above the map acts as the full map.
    write_register(CFG_USED_BITS, 11'd2047);
    issue_request(OP_ALLOC, 10'd0, 11'd1024, 1'b1);
    write_register(CFG_USED_BITS, 11'd37);
    issue_request(OP_TEST, 10'd40, 11'd0, 1'b0);       // past the used size
    issue_request(OP_ALLOC, 10'd0, 11'd38, 1'b0);

    // Random phases, each under its own register setting; the last one runs without idling.
    foreach (used_setting[p]) begin
      write_register(CFG_USED_BITS, 11'(used_setting[p]));
      write_register(CFG_FILL_VALUE, 11'(p % 2));
      idle_enable = (p != 9);
      repeat (PhaseItems) issue_random_request();
    end

    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);

    $display("Sent %0d alloc, %0d write, %0d test and %0d fill requests over %0d register writes.",
             op_count[OP_ALLOC], op_count[OP_WRITE], op_count[OP_TEST], op_count[OP_FILL],
             reg_writes);
    $display("Compared %0d results, %0d mismatches.", checked, error_count);
    if (error_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
